// File: rtl/adic_pkg.sv
// Package for the analog/digital input classifier: word types, register indexes, status codes
`timescale 1ns / 1ps

package adic_pkg;

    // fixed field widths
    localparam int SAMPLE_BITS = 12;
    localparam int LEVEL_BITS  = 12;
    localparam int MASK_BITS   = 16;
    localparam int CHAN_BITS   = 4;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ON_LEVEL     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OPEN_LEVEL   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SHORT_LEVEL  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DIGITAL_MASK = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ANALOG_MASK  = 3'd4;

    // reset values of the levels
    localparam logic [LEVEL_BITS-1:0] ON_LEVEL_RST    = 12'd950;
    localparam logic [LEVEL_BITS-1:0] OPEN_LEVEL_RST  = 12'd300;
    localparam logic [LEVEL_BITS-1:0] SHORT_LEVEL_RST = 12'd2000;

    // channel status codes
    localparam logic [1:0] CODE_ON    = 2'd0;
    localparam logic [1:0] CODE_OFF   = 2'd1;
    localparam logic [1:0] CODE_FAULT = 2'd3;

    typedef struct packed {
        logic [CHAN_BITS-1:0]   channel;
        logic [SAMPLE_BITS-1:0] sample;
        logic                   scan_end;
        logic [MASK_BITS-1:0]   change_ack;
    } item_word_t;

    typedef struct packed {
        logic                   is_on;
        logic                   is_open;
        logic                   is_short;
        logic                   is_fault;
        logic                   changed_now;
        logic [1:0]             status_code;
        logic [MASK_BITS-1:0]   on_mask;
        logic [MASK_BITS-1:0]   short_mask;
        logic [MASK_BITS-1:0]   open_mask;
        logic [MASK_BITS-1:0]   fault_mask;
        logic [MASK_BITS-1:0]   change_mask;
        logic [2*MASK_BITS-1:0] packed_codes;
    } result_word_t;

    function automatic logic [1:0] code_of(input logic on, input logic fault);
        logic [1:0] code;
        if (fault)
            code = CODE_FAULT;
        else if (on)
            code = CODE_ON;
        else
            code = CODE_OFF;
        return code;
    endfunction

endpackage

// File: rtl/analog_digital_input_classifier.sv
// Top level: per-channel on/break/short classification with scan masks and sticky changes
// An accepted word is held in the input register, and its result in the result register.
// Throughput: one word per cycle while not stalled; the held per-channel flags and masks are
// updated as a word moves from the input register into the result register.
// Reset (rst_n low, asynchronous): levels to 950/300/2000, channel masks, held flags,
// accumulated and published masks and sticky changes to zero; both registers empty.
`timescale 1ns / 1ps

module analog_digital_input_classifier
    import adic_pkg::*;
#(
    parameter int CHANNELS = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  item_valid,
    output logic                  item_stall,
    input  item_word_t            item,
    output logic                  result_valid,
    input  logic                  result_stall,
    output result_word_t          result
);

    // configuration registers
    logic [LEVEL_BITS-1:0] on_level_reg;
    logic [LEVEL_BITS-1:0] open_level_reg;
    logic [LEVEL_BITS-1:0] short_level_reg;
    logic [CHANNELS-1:0]   digital_reg;
    logic [CHANNELS-1:0]   analog_reg;

    // pipeline registers
    logic         item_valid_reg;
    item_word_t   item_reg;
    logic         result_valid_reg;
    result_word_t result_reg;

    // channel state
    logic [CHANNELS-1:0] held_on_reg,    held_on_next;
    logic [CHANNELS-1:0] held_fault_reg, held_fault_next;
    logic [CHANNELS-1:0] acc_on_reg,     acc_on_next;
    logic [CHANNELS-1:0] acc_short_reg,  acc_short_next;
    logic [CHANNELS-1:0] acc_open_reg,   acc_open_next;
    logic [CHANNELS-1:0] acc_fault_reg,  acc_fault_next;
    logic [CHANNELS-1:0] pub_on_reg,     pub_on_next;
    logic [CHANNELS-1:0] pub_short_reg,  pub_short_next;
    logic [CHANNELS-1:0] pub_open_reg,   pub_open_next;
    logic [CHANNELS-1:0] pub_fault_reg,  pub_fault_next;
    logic [CHANNELS-1:0] sticky_reg,     sticky_next;

    logic                 result_free;
    logic                 advance;
    logic [MASK_BITS-1:0] sel_all;
    logic [CHANNELS-1:0]  sel;
    logic [CHANNELS-1:0]  hit;
    logic                 proc;
    logic                 on_raw;
    logic                 brk;
    logic                 sht;
    logic                 on_now;
    logic                 flt_now;
    logic                 old_on;
    logic                 old_flt;
    logic                 chg;
    logic                 new_on;
    logic                 new_flt;
    logic [2*MASK_BITS-1:0] codes;
    result_word_t         result_next;

    // handshake
    assign result_free  = !result_valid_reg || !result_stall;
    assign advance      = item_valid_reg && result_free;
    assign item_stall   = item_valid_reg && !result_free;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            on_level_reg    <= ON_LEVEL_RST;
            open_level_reg  <= OPEN_LEVEL_RST;
            short_level_reg <= SHORT_LEVEL_RST;
            digital_reg     <= '0;
            analog_reg      <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_ON_LEVEL:     on_level_reg    <= cfg_data[LEVEL_BITS-1:0];
                REG_OPEN_LEVEL:   open_level_reg  <= cfg_data[LEVEL_BITS-1:0];
                REG_SHORT_LEVEL:  short_level_reg <= cfg_data[LEVEL_BITS-1:0];
                REG_DIGITAL_MASK: digital_reg     <= cfg_data[CHANNELS-1:0];
                REG_ANALOG_MASK:  analog_reg      <= cfg_data[CHANNELS-1:0];
                default:          ;
            endcase
        end
    end

    // channel select; a channel at or beyond CHANNELS selects nothing
    assign sel_all = MASK_BITS'(1) << item_reg.channel;
    assign sel     = sel_all[CHANNELS-1:0];
    assign proc    = |(sel & digital_reg & ~analog_reg);
    assign hit     = proc ? sel : '0;

    // window comparisons
    assign on_raw  = item_reg.sample >= on_level_reg;
    assign brk     = item_reg.sample <= open_level_reg;
    assign sht     = item_reg.sample >= short_level_reg;
    assign on_now  = on_raw && !sht;
    assign flt_now = brk || sht;

    // held values of the addressed channel
    assign old_on  = |(held_on_reg & sel);
    assign old_flt = |(held_fault_reg & sel);
    assign chg     = proc && ((on_now != old_on) || (flt_now != old_flt));
    assign new_on  = proc ? on_now : old_on;
    assign new_flt = proc ? flt_now : old_flt;

    // state next values
    always_comb
    begin
        held_on_next    = (held_on_reg & ~hit) | (on_now ? hit : '0);
        held_fault_next = (held_fault_reg & ~hit) | (flt_now ? hit : '0);
        acc_on_next     = acc_on_reg | (on_now ? hit : '0);
        acc_short_next  = acc_short_reg | (sht ? hit : '0);
        acc_open_next   = acc_open_reg | (brk ? hit : '0);
        acc_fault_next  = acc_fault_reg | (flt_now ? hit : '0);
        pub_on_next     = pub_on_reg;
        pub_short_next  = pub_short_reg;
        pub_open_next   = pub_open_reg;
        pub_fault_next  = pub_fault_reg;
        sticky_next     = (sticky_reg & ~item_reg.change_ack[CHANNELS-1:0])
                          | (chg ? sel : '0);
        if (item_reg.scan_end)
        begin
            pub_on_next    = acc_on_next;
            pub_short_next = acc_short_next;
            pub_open_next  = acc_open_next;
            pub_fault_next = acc_fault_next;
            acc_on_next    = '0;
            acc_short_next = '0;
            acc_open_next  = '0;
            acc_fault_next = '0;
        end
    end

    // packed status codes from the updated held values
    for (genvar g = 0; g < MASK_BITS; g++)
    begin : g_codes
        if (g < CHANNELS)
        begin : g_live
            assign codes[2*g +: 2] = code_of(held_on_next[g], held_fault_next[g]);
        end
        else
        begin : g_unused
            assign codes[2*g +: 2] = 2'b00;
        end
    end

    // result word
    always_comb
    begin
        result_next.is_on        = new_on;
        result_next.is_open      = proc && brk;
        result_next.is_short     = proc && sht;
        result_next.is_fault     = new_flt;
        result_next.changed_now  = chg;
        result_next.status_code  = code_of(new_on, new_flt);
        result_next.on_mask      = MASK_BITS'(pub_on_next);
        result_next.short_mask   = MASK_BITS'(pub_short_next);
        result_next.open_mask    = MASK_BITS'(pub_open_next);
        result_next.fault_mask   = MASK_BITS'(pub_fault_next);
        result_next.change_mask  = MASK_BITS'(sticky_next);
        result_next.packed_codes = codes;
    end

    // valid flags and channel state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
            held_on_reg      <= '0;
            held_fault_reg   <= '0;
            acc_on_reg       <= '0;
            acc_short_reg    <= '0;
            acc_open_reg     <= '0;
            acc_fault_reg    <= '0;
            pub_on_reg       <= '0;
            pub_short_reg    <= '0;
            pub_open_reg     <= '0;
            pub_fault_reg    <= '0;
            sticky_reg       <= '0;
        end
        else
        begin
            if (!item_stall)
                item_valid_reg <= item_valid;
            if (result_free)
                result_valid_reg <= item_valid_reg;
            if (advance)
            begin
                held_on_reg    <= held_on_next;
                held_fault_reg <= held_fault_next;
                acc_on_reg     <= acc_on_next;
                acc_short_reg  <= acc_short_next;
                acc_open_reg   <= acc_open_next;
                acc_fault_reg  <= acc_fault_next;
                pub_on_reg     <= pub_on_next;
                pub_short_reg  <= pub_short_next;
                pub_open_reg   <= pub_open_next;
                pub_fault_reg  <= pub_fault_next;
                sticky_reg     <= sticky_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (!item_stall && item_valid)
            item_reg <= item;
        if (advance)
            result_reg <= result_next;
    end

endmodule

// File: test/analog_digital_input_classifier_tb.sv
// Testbench for the analog/digital input classifier: directed edge cases, random scans, scoreboard
`timescale 1ns / 1ps

module analog_digital_input_classifier_tb;
    import adic_pkg::*;

    localparam int CLK_HALF    = 4;
    localparam int RESET_TICKS = 6;
    localparam int SETTLE_TICKS = 4;
    localparam int CYCLE_LIMIT = 250000;
    localparam int NUM_CHAN    = 16;
    localparam int LOUD_LIMIT  = 50;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  item_valid = 1'b0;
    logic                  item_stall;
    item_word_t            item = '0;
    logic                  result_valid;
    logic                  result_stall = 1'b0;
    result_word_t          result;

    // idling rates in percent, changed per phase
    int unsigned sender_idle_pct = 0;
    int unsigned receiver_stall_pct = 0;

    int unsigned cycle_count = 0;
    int unsigned mismatch_count = 0;
    int unsigned words_checked = 0;

    // predicted classifier state and register copies
    logic [LEVEL_BITS-1:0] on_lvl = ON_LEVEL_RST;
    logic [LEVEL_BITS-1:0] open_lvl = OPEN_LEVEL_RST;
    logic [LEVEL_BITS-1:0] short_lvl = SHORT_LEVEL_RST;
    logic [MASK_BITS-1:0]  digital_types = '0;
    logic [MASK_BITS-1:0]  analog_claims = '0;
    logic [MASK_BITS-1:0]  held_on = '0;
    logic [MASK_BITS-1:0]  held_fault = '0;
    logic [MASK_BITS-1:0]  acc_on = '0, acc_short = '0, acc_open = '0, acc_fault = '0;
    logic [MASK_BITS-1:0]  pub_on = '0, pub_short = '0, pub_open = '0, pub_fault = '0;
    logic [MASK_BITS-1:0]  sticky_chg = '0;

    result_word_t predicted_words[$];

    analog_digital_input_classifier DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    // clock
    always #CLK_HALF clk = ~clk;

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // receiver back-pressure
    always @(negedge clk)
    begin
        result_stall <= ($urandom_range(99) < receiver_stall_pct);
    end

    // line status code from held flags
    function automatic logic [1:0] line_code(input logic on, input logic fault);
        if (fault)
            return CODE_FAULT;
        return on ? CODE_ON : CODE_OFF;
    endfunction

    // expected result of one word, advancing the predicted state
    function automatic result_word_t classify_word(input item_word_t w);
        result_word_t         r;
        logic [MASK_BITS-1:0] sel;
        logic                 hit_on, hit_open, hit_short, hit_fault;
        r = '0;
        sel = 16'b1 << w.channel;
        sticky_chg = sticky_chg & ~w.change_ack;
        if ((digital_types & sel) != 0 && (analog_claims & sel) == 0)
        begin
            hit_on = (w.sample >= on_lvl);
            hit_open = (w.sample <= open_lvl);
            hit_short = (w.sample >= short_lvl);
            // a short always reads as off
            if (hit_short)
                hit_on = 1'b0;
            hit_fault = hit_open | hit_short;
            if (hit_on) acc_on = acc_on | sel;
            if (hit_short) acc_short = acc_short | sel;
            if (hit_open) acc_open = acc_open | sel;
            if (hit_fault) acc_fault = acc_fault | sel;
            if (hit_on != held_on[w.channel] || hit_fault != held_fault[w.channel])
            begin
                r.changed_now = 1'b1;
                sticky_chg = sticky_chg | sel;
                held_on[w.channel] = hit_on;
                held_fault[w.channel] = hit_fault;
            end
            r.is_open = hit_open;
            r.is_short = hit_short;
        end
        r.is_on = held_on[w.channel];
        r.is_fault = held_fault[w.channel];
        r.status_code = line_code(r.is_on, r.is_fault);
        // scan end publishes after this word's own contribution
        if (w.scan_end)
        begin
            pub_on = acc_on;
            pub_short = acc_short;
            pub_open = acc_open;
            pub_fault = acc_fault;
            acc_on = '0;
            acc_short = '0;
            acc_open = '0;
            acc_fault = '0;
        end
        for (int i = 0; i < NUM_CHAN; i++)
            r.packed_codes[2*i +: 2] = line_code(held_on[i], held_fault[i]);
        r.on_mask = pub_on;
        r.short_mask = pub_short;
        r.open_mask = pub_open;
        r.fault_mask = pub_fault;
        r.change_mask = sticky_chg;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatch_count < LOUD_LIMIT)
            $display("mismatch word %0d %s: got %h want %h", words_checked, what, got, want);
        mismatch_count++;
    endtask

    // result checker
    always @(posedge clk)
    begin
        result_word_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (predicted_words.size() == 0)
                report_mismatch("unexpected word", result.packed_codes, 32'(0));
            else
            begin
                want = predicted_words.pop_front();
                if (result.is_on !== want.is_on)
                    report_mismatch("is_on", 32'(result.is_on), 32'(want.is_on));
                if (result.is_open !== want.is_open)
                    report_mismatch("is_open", 32'(result.is_open), 32'(want.is_open));
                if (result.is_short !== want.is_short)
                    report_mismatch("is_short", 32'(result.is_short), 32'(want.is_short));
                if (result.is_fault !== want.is_fault)
                    report_mismatch("is_fault", 32'(result.is_fault), 32'(want.is_fault));
                if (result.changed_now !== want.changed_now)
                    report_mismatch("changed_now", 32'(result.changed_now),
                                    32'(want.changed_now));
                if (result.status_code !== want.status_code)
                    report_mismatch("status_code", 32'(result.status_code),
                                    32'(want.status_code));
                if (result.on_mask !== want.on_mask)
                    report_mismatch("on_mask", 32'(result.on_mask), 32'(want.on_mask));
                if (result.short_mask !== want.short_mask)
                    report_mismatch("short_mask", 32'(result.short_mask), 32'(want.short_mask));
                if (result.open_mask !== want.open_mask)
                    report_mismatch("open_mask", 32'(result.open_mask), 32'(want.open_mask));
                if (result.fault_mask !== want.fault_mask)
                    report_mismatch("fault_mask", 32'(result.fault_mask), 32'(want.fault_mask));
                if (result.change_mask !== want.change_mask)
                    report_mismatch("change_mask", 32'(result.change_mask),
                                    32'(want.change_mask));
                if (result.packed_codes !== want.packed_codes)
                    report_mismatch("packed_codes", result.packed_codes, want.packed_codes);
            end
            words_checked++;
        end
    end

    // send one word, predicting it once accepted
    task automatic send_word(input logic [CHAN_BITS-1:0] ch, input logic [SAMPLE_BITS-1:0] smp,
                             input logic last, input logic [MASK_BITS-1:0] ack);
        item_word_t w;
        w.channel = ch;
        w.sample = smp;
        w.scan_end = last;
        w.change_ack = ack;
        @(negedge clk);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            item_valid <= 1'b0;
            @(negedge clk);
        end
        item_valid <= 1'b1;
        item <= w;
        do
            @(posedge clk);
        while (item_stall);
        predicted_words.push_back(classify_word(w));
    endtask

    // stop sending and let the pipeline empty
    task automatic drain_block;
        @(negedge clk);
        item_valid <= 1'b0;
        while (predicted_words.size() != 0)
            @(negedge clk);
        repeat (SETTLE_TICKS) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            REG_ON_LEVEL:     on_lvl = val[LEVEL_BITS-1:0];
            REG_OPEN_LEVEL:   open_lvl = val[LEVEL_BITS-1:0];
            REG_SHORT_LEVEL:  short_lvl = val[LEVEL_BITS-1:0];
            REG_DIGITAL_MASK: digital_types = val;
            REG_ANALOG_MASK:  analog_claims = val;
            default: ;
        endcase
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic set_levels(input int on_v, input int open_v, input int short_v);
        write_reg(REG_ON_LEVEL, CFG_DATA_W'(on_v));
        write_reg(REG_OPEN_LEVEL, CFG_DATA_W'(open_v));
        write_reg(REG_SHORT_LEVEL, CFG_DATA_W'(short_v));
    endtask

    // with both channel masks clear every word is skipped
    task automatic test_skipped_at_reset;
        send_word(4'd0, 12'hFFF, 1'b0, 16'h0000);
        send_word(4'd9, 12'd0, 1'b1, 16'hFFFF);
    endtask

    // default levels, samples on and around each threshold
    task automatic test_threshold_edges;
        drain_block();
        write_reg(REG_DIGITAL_MASK, 16'hFFFF);
        send_word(4'd0, 12'd0, 1'b0, 16'h0000);
        send_word(4'd0, 12'd300, 1'b0, 16'h0000);
        send_word(4'd0, 12'd301, 1'b0, 16'h0000);
        send_word(4'd1, 12'd949, 1'b0, 16'h0000);
        send_word(4'd1, 12'd950, 1'b0, 16'h0000);
        send_word(4'd2, 12'd1999, 1'b0, 16'h0000);
        send_word(4'd2, 12'd2000, 1'b0, 16'h0000);
        send_word(4'd15, 12'hFFF, 1'b1, 16'h0000);
        // a one-word scan publishes only its own bits
        send_word(4'd15, 12'hFFF, 1'b1, 16'h0000);
        send_word(4'd3, 12'd1000, 1'b0, 16'hFFFF);
    endtask

    // channels claimed for analog use are skipped even when digital
    task automatic test_analog_claim;
        drain_block();
        write_reg(REG_ANALOG_MASK, 16'h8001);
        send_word(4'd0, 12'hFFF, 1'b0, 16'h0000);
        send_word(4'd15, 12'd0, 1'b0, 16'h0000);
        send_word(4'd7, 12'd2000, 1'b1, 16'h8000);
    endtask

    // levels at the ends of their range
    task automatic test_level_extremes;
        drain_block();
        write_reg(REG_ANALOG_MASK, 16'h0000);
        // on and break together at sample zero; the top sample is a short
        set_levels(0, 0, 4095);
        send_word(4'd4, 12'd0, 1'b0, 16'h0000);
        send_word(4'd4, 12'hFFF, 1'b0, 16'h0000);
        send_word(4'd5, 12'd1, 1'b0, 16'h0000);
        drain_block();
        // every sample is both a short and a break
        set_levels(4095, 4095, 0);
        send_word(4'd6, 12'd0, 1'b0, 16'h0000);
        send_word(4'd6, 12'hFFF, 1'b1, 16'hFFFF);
    endtask

    function automatic logic [SAMPLE_BITS-1:0] pick_sample;
        int v;
        case ($urandom_range(9))
            0: v = on_lvl + $urandom_range(4) - 2;
            1: v = open_lvl + $urandom_range(4) - 2;
            2: v = short_lvl + $urandom_range(4) - 2;
            3: v = $urandom_range(1) ? 4095 : 0;
            default: v = $urandom_range(4095);
        endcase
        if (v < 0) v = 0;
        if (v > 4095) v = 4095;
        return SAMPLE_BITS'(v);
    endfunction

    function automatic logic [MASK_BITS-1:0] pick_ack;
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 80) return '0;
        if (roll < 95) return MASK_BITS'($urandom);
        return '1;
    endfunction

    task automatic pick_config(input int unsigned setting);
        int a, b, c;
        drain_block();
        if (setting == 0 || $urandom_range(4) == 0)
        begin
            a = $urandom_range(1) ? 4095 : 0;
            b = $urandom_range(1) ? 4095 : 0;
            c = $urandom_range(1) ? 4095 : 0;
        end
        else
        begin
            // ordered levels as a real front end would use them
            b = $urandom_range(1500);
            a = b + $urandom_range(1200);
            c = a + $urandom_range(1500);
            if (c > 4095) c = 4095;
        end
        set_levels(a, b, c);
        write_reg(REG_DIGITAL_MASK, ($urandom_range(3) == 0) ? 16'hFFFF
                                                             : MASK_BITS'($urandom | $urandom));
        write_reg(REG_ANALOG_MASK, MASK_BITS'($urandom & $urandom & $urandom));
    endtask

    // random scans with random content, some noise words in between
    task automatic test_random_traffic(input int unsigned send_pct, input int unsigned recv_pct,
                                       input int unsigned words);
        int unsigned sent;
        int unsigned len;
        int unsigned setting;
        sent = 0;
        setting = 0;
        drain_block();
        sender_idle_pct = send_pct;
        receiver_stall_pct = recv_pct;
        while (sent < words)
        begin
            if (sent >= setting * (words / 4))
            begin
                pick_config(setting);
                setting++;
            end
            if ($urandom_range(9) < 8)
            begin
                len = $urandom_range(1, NUM_CHAN);
                for (int c = 0; c < len; c++)
                    send_word(CHAN_BITS'(c), pick_sample(), (c == len - 1), pick_ack());
                sent += len;
            end
            else
            begin
                send_word(CHAN_BITS'($urandom), pick_sample(), 1'($urandom_range(1)),
                          pick_ack());
                sent++;
            end
        end
    endtask

    initial
    begin
        repeat (RESET_TICKS) @(negedge clk);
        rst_n = 1'b1;
        test_skipped_at_reset();
        test_threshold_edges();
        test_analog_claim();
        test_level_extremes();
        test_random_traffic(8, 45, 400);
        test_random_traffic(45, 8, 400);
        test_random_traffic(0, 0, 400);
        drain_block();
        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
